>>> rtl/nqc_pkg.sv
// Shared constants and types for the N-queens solution counter.
package nqc_pkg;

  localparam int MaxBoardDefault = 16;
  localparam int SizeWidth       = 5;
  localparam int CountWidth      = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // Per-row cell command: load masks from the row above, or strike the lowest candidate.
  typedef struct packed {
    logic load;
    logic take;
  } cell_ctrl_t;

endpackage

>>> rtl/nqc_cell.sv
// One board row of the search chain: attack masks from above and the remaining candidate columns.
module nqc_cell import nqc_pkg::*; #(
  parameter int Width = MaxBoardDefault
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [Width-1:0] board_mask,
  input  logic [Width-1:0] cols_in,
  input  logic [Width-1:0] ld_in,
  input  logic [Width-1:0] rd_in,
  output logic [Width-1:0] cols_out,
  output logic [Width-1:0] ld_out,
  output logic [Width-1:0] rd_out,
  output logic             empty
);

  logic [Width-1:0] cols;
  logic [Width-1:0] ld;
  logic [Width-1:0] rd;
  logic [Width-1:0] avail;
  logic [Width-1:0] lowbit;

  // isolate the lowest free column
  assign lowbit = avail & (~avail + Width'(1));
  assign empty  = (avail == '0);

  // masks handed to the next row if the lowest candidate is placed
  assign cols_out = cols | lowbit;
  assign ld_out   = (ld | lowbit) << 1;
  assign rd_out   = (rd | lowbit) >> 1;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cols  <= cols_in;
      ld    <= ld_in;
      rd    <= rd_in;
      avail <= ~(cols_in | ld_in | rd_in) & board_mask;
    end else if (ctrl.take) begin
      avail <= avail & ~lowbit;
    end
  end

endmodule

>>> rtl/n_queens_solution_counter.sv
// Top level: depth-first N-queens search over a chain of row cells.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------
//  request | req_valid | req_stall | board_size [4:0]
//  result  | rsp_valid | rsp_stall | solution_count [23:0]
//
// One request at a time. After acceptance the search first loads the root row, then each
// step either places the next candidate of the active row or backs up one row, until
// the root row is found empty and the result is presented.
// Size 0 and sizes above MAX_BOARD present the result in the cycle after acceptance.
// req_stall is high from acceptance until the result is taken; the result holds
// under rsp_stall. Reset (rst, synchronous) returns to idle; counts saturate at 24 bits.
module n_queens_solution_counter import nqc_pkg::*; #(
  parameter int MAX_BOARD = MaxBoardDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [SizeWidth-1:0]  board_size,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [CountWidth-1:0] solution_count
);

  localparam int DW = $clog2(MAX_BOARD);

  state_t                state, state_next;
  logic [DW-1:0]         depth, depth_next;
  logic [DW-1:0]         last_row, last_row_next;
  logic [CountWidth-1:0] count, count_next;
  logic [MAX_BOARD-1:0]  board_mask, board_mask_next;

  logic [MAX_BOARD-1:0] cols_link [MAX_BOARD+1];
  logic [MAX_BOARD-1:0] ld_link   [MAX_BOARD+1];
  logic [MAX_BOARD-1:0] rd_link   [MAX_BOARD+1];
  logic [MAX_BOARD-1:0] empty_vec;
  cell_ctrl_t           cell_ctrl [MAX_BOARD];

  logic root_load;
  logic descend;
  logic take_en;

  // marks the first search cycle, when cell 0 still holds stale masks
  logic root_pending;

  assign cols_link[0] = '0;
  assign ld_link[0]   = '0;
  assign rd_link[0]   = '0;

  for (genvar i = 0; i < MAX_BOARD; i++) begin : g_row
    if (i == 0) begin : g_first
      assign cell_ctrl[i].load = root_load;
    end else begin : g_rest
      assign cell_ctrl[i].load = descend && (depth == DW'(i - 1));
    end
    assign cell_ctrl[i].take = take_en && (depth == DW'(i));

    nqc_cell #(
      .Width (MAX_BOARD)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .board_mask (board_mask),
      .cols_in    (cols_link[i]),
      .ld_in      (ld_link[i]),
      .rd_in      (rd_link[i]),
      .cols_out   (cols_link[i+1]),
      .ld_out     (ld_link[i+1]),
      .rd_out     (rd_link[i+1]),
      .empty      (empty_vec[i])
    );
  end

  assign req_stall      = (state != ST_IDLE);
  assign rsp_valid      = (state == ST_DONE);
  assign solution_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    depth      <= depth_next;
    last_row   <= last_row_next;
    count      <= count_next;
    board_mask <= board_mask_next;
  end

  always_comb begin
    state_next      = state;
    depth_next      = depth;
    last_row_next   = last_row;
    count_next      = count;
    board_mask_next = board_mask;
    root_load       = 1'b0;
    descend         = 1'b0;
    take_en         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          for (int i = 0; i < MAX_BOARD; i++) begin
            board_mask_next[i] = (SizeWidth'(i) < board_size);
          end
          depth_next    = '0;
          last_row_next = DW'(board_size - SizeWidth'(1));
          if (board_size == '0) begin
            count_next = CountWidth'(1);
            state_next = ST_DONE;
          end else if (board_size > SizeWidth'(MAX_BOARD)) begin
            count_next = '0;
            state_next = ST_DONE;
          end else begin
            count_next = '0;
            state_next = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // first cycle in SEARCH loads the root row; board_mask is now valid
        if (empty_vec[depth]) begin
          if (depth == '0) begin
            state_next = ST_DONE;
          end else begin
            depth_next = depth - DW'(1);
          end
        end else begin
          take_en = 1'b1;
          if (depth == last_row) begin
            if (count != '1) begin
              count_next = count + CountWidth'(1);
            end
          end else begin
            descend    = 1'b1;
            depth_next = depth + DW'(1);
          end
        end
      end

      ST_DONE: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // root row does not load on the request that starts a search: board_mask is registered,
    // so cell 0 would still see the old mask; it loads on the first search cycle instead
    if (state == ST_SEARCH && root_pending) begin
      root_load = 1'b1;
      take_en   = 1'b0;
      descend   = 1'b0;
      depth_next = '0;
      count_next = count;
      state_next = ST_SEARCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_pending <= 1'b0;
    end else begin
      root_pending <= (state == ST_IDLE) && req_valid &&
                      (board_size != '0) && (board_size <= SizeWidth'(MAX_BOARD));
    end
  end

endmodule

>>> sim/nqc_result_checker.sv
// Checker for the N-queens counter: predicts each count and compares the results.
`timescale 1ns / 1ps

module nqc_result_checker import nqc_pkg::*; #(
  parameter int MAX_BOARD = MaxBoardDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic [SizeWidth-1:0]  board_size,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic [CountWidth-1:0] solution_count,
  output int                    mismatches,
  output int                    outstanding
);

  localparam logic [CountWidth-1:0] CountSat = {CountWidth{1'b1}};

  logic [CountWidth-1:0] expected_counts [$];
  logic [SizeWidth-1:0]  pending_sizes [$];

  // Known placement counts; refused sizes give 0, wide counts saturate.
  function automatic logic [CountWidth-1:0] placements_for_size(logic [SizeWidth-1:0] n);
    logic [63:0] full;
    if (n > MAX_BOARD || n > 20) return '0;
    case (n)
      5'd0:  full = 64'd1;
      5'd1:  full = 64'd1;
      5'd2:  full = 64'd0;
      5'd3:  full = 64'd0;
      5'd4:  full = 64'd2;
      5'd5:  full = 64'd10;
      5'd6:  full = 64'd4;
      5'd7:  full = 64'd40;
      5'd8:  full = 64'd92;
      5'd9:  full = 64'd352;
      5'd10: full = 64'd724;
      5'd11: full = 64'd2680;
      5'd12: full = 64'd14200;
      5'd13: full = 64'd73712;
      5'd14: full = 64'd365596;
      5'd15: full = 64'd2279184;
      5'd16: full = 64'd14772512;
      5'd17: full = 64'd95815104;
      5'd18: full = 64'd666090624;
      5'd19: full = 64'd4968057848;
      default: full = 64'd39029188884;
    endcase
    if (full > {40'd0, CountSat}) return CountSat;
    return full[CountWidth-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    logic [CountWidth-1:0] want;
    logic [SizeWidth-1:0]  sz;
    if (!rst) begin
      // check the result before queuing a new request so nothing matches early
      if (rsp_valid && !rsp_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request waiting", solution_count));
        end else begin
          want = expected_counts.pop_front();
          sz   = pending_sizes.pop_front();
          if (solution_count !== want)
            report_mismatch($sformatf("N=%0d: solution_count %0d, expected %0d",
                                      sz, solution_count, want));
        end
      end
      if (req_valid && !req_stall) begin
        expected_counts = {expected_counts, placements_for_size(board_size)};
        pending_sizes   = {pending_sizes, board_size};
      end
      outstanding <= expected_counts.size();
    end
  end

endmodule

>>> sim/testbench.sv
// Top of the N-queens counter testbench: clock, reset, request and result drivers, verdict.
`timescale 1ns / 1ps

module testbench;
  import nqc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  logic [SizeWidth-1:0]  board_size;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic [CountWidth-1:0] solution_count;
  int                    mismatches;
  int                    outstanding;

  localparam int NumRandom = 82;

  // searched sizes stay at 11 or below; the larger sizes listed are all refused
  int unsigned directed_sizes [18] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
                                       17, 20, 21, 24, 30, 31};

  n_queens_solution_counter #(.MAX_BOARD(MaxBoardDefault)) DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .board_size     (board_size),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .solution_count (solution_count)
  );

  nqc_result_checker #(.MAX_BOARD(MaxBoardDefault)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .board_size     (board_size),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .solution_count (solution_count),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly small boards, a few near the top of the affordable range, some refused
  function automatic logic [SizeWidth-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return SizeWidth'($urandom_range(31, 17));
    if (r < 18) return SizeWidth'($urandom_range(10, 9));
    return SizeWidth'($urandom_range(8, 0));
  endfunction

  task automatic send_request(logic [SizeWidth-1:0] n, bit calm);
    if (!calm && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    board_size <= n;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // result side: one long hold-off right after reset, then random stalls, none while results 40 to 69 are taken
  initial begin
    int taken;
    taken     = 0;
    rsp_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    rsp_stall <= 1'b1;
    repeat (400) @(posedge clk);
    forever begin
      if (taken >= 40 && taken < 70) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 27);
      @(posedge clk);
      if (rsp_valid && !rsp_stall) taken++;
    end
  end

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    board_size = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_sizes[i]) send_request(SizeWidth'(directed_sizes[i]), 1'b0);
    for (int i = 0; i < NumRandom; i++) send_request(pick_size(), i >= 50 && i < 75);
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("** n_queens_solution_counter: PASSED **");
    end else begin
      $display("** n_queens_solution_counter: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("** n_queens_solution_counter: FAILED **");
    $finish;
  end

endmodule
